// ===== rtl/tcc_pkg.sv =====
// ---------------------------------------------------------------------------
// Tree connectivity cycle check package
// Shared codes, default sizes, controller states and store write request.
// ---------------------------------------------------------------------------
package tcc_pkg;

    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_MAX_EDGES = 2048;

    localparam logic [1:0] FUNC_NODE  = 2'd0;
    localparam logic [1:0] FUNC_EDGE  = 2'd1;
    localparam logic [1:0] FUNC_CHECK = 2'd2;

    localparam logic [2:0] VERD_VALID    = 3'd0;
    localparam logic [2:0] VERD_CYCLE    = 3'd1;
    localparam logic [2:0] VERD_NODE     = 3'd2;
    localparam logic [2:0] VERD_EDGE     = 3'd3;
    localparam logic [2:0] VERD_OVERFLOW = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_VISIT,
        S_RANGE,
        S_EREAD,
        S_TREAD,
        S_DECIDE,
        S_NEXT,
        S_POP1,
        S_POP2,
        S_SN_RD,
        S_SN_CK,
        S_SE_RD,
        S_SE_CK
    } state_t;

    typedef struct packed {
        logic        node_we;
        logic        edge_we;
        logic [10:0] first;
        logic [10:0] last;
        logic [9:0]  from;
        logic [9:0]  to;
    } graph_wr_t;

endpackage

// ===== rtl/tcc_graph_store.sv =====
// ---------------------------------------------------------------------------
// Graph store
// Node range memory and edge endpoint memory, one write and one registered
// read port each.
// ---------------------------------------------------------------------------
module tcc_graph_store #(
    parameter int MAX_NODES = tcc_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = tcc_pkg::DEF_MAX_EDGES,
    localparam int NW = $clog2(MAX_NODES),
    localparam int EW = $clog2(MAX_EDGES)
) (
    input  logic              clk,
    input  tcc_pkg::graph_wr_t wr,
    input  logic [NW-1:0]     node_waddr,
    input  logic [EW-1:0]     edge_waddr,
    input  logic [NW-1:0]     node_raddr,
    input  logic [EW-1:0]     edge_raddr,
    output logic [10:0]       first_rd,
    output logic [10:0]       last_rd,
    output logic [9:0]        from_rd,
    output logic [9:0]        to_rd
);

    logic [21:0] node_mem [MAX_NODES];
    logic [19:0] edge_mem [MAX_EDGES];

    always_ff @(posedge clk)
    begin
        if (wr.node_we)
        begin
            node_mem[node_waddr] <= {wr.first, wr.last};
        end
        {first_rd, last_rd} <= node_mem[node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.edge_we)
        begin
            edge_mem[edge_waddr] <= {wr.from, wr.to};
        end
        {from_rd, to_rd} <= edge_mem[edge_raddr];
    end

endmodule

// ===== rtl/tree_connectivity_cycle_check.sv =====
// ---------------------------------------------------------------------------
// Tree connectivity cycle check
// Loads a graph in adjacency-array form and checks it is a tree by a
// depth-first walk from node 0 over an edge stack.
// ---------------------------------------------------------------------------
// Load words are written straight to the store and busy stays low, so they run
// one per cycle while no check word is running. A check word first clears the mark
// memories, then walks the graph, visiting nodes, popping the stack and scanning
// edges, and ends with scans over the nodes and the edges; the verdict strobes for one
// cycle after the last step, and a new word can be taken in that cycle. Reset clears
// control state and sets node_count to 1; memory contents are undefined until written.
module tree_connectivity_cycle_check #(
    parameter int MAX_NODES = tcc_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = tcc_pkg::DEF_MAX_EDGES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [10:0] entry_index,
    input  logic [10:0] range_first,
    input  logic [10:0] range_last,
    input  logic [9:0]  edge_from,
    input  logic [9:0]  edge_to,
    output logic        verdict_valid,
    output logic [2:0]  verdict
);

    localparam int NW   = $clog2(MAX_NODES);
    localparam int EW   = $clog2(MAX_EDGES);
    localparam int MAXD = (MAX_NODES > MAX_EDGES) ? MAX_NODES : MAX_EDGES;
    localparam int CW   = $clog2(MAXD);
    localparam int DW   = $clog2(MAX_NODES + 1);

    tcc_pkg::state_t state_reg, state_next;
    logic [10:0]   node_count_reg;
    logic [DW-1:0] n_eff;
    logic [DW:0]   edge_lim;
    logic [CW-1:0] clr_reg, clr_next;
    logic [DW:0]   scan_reg, scan_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [10:0]   i_reg, i_next;
    logic [10:0]   last_reg, last_next;
    logic [EW-1:0] e_reg, e_next;
    logic [NW-1:0] tgt_reg, tgt_next;
    logic [NW-1:0] curr_reg, curr_next;
    logic [NW-1:0] par_reg, par_next;
    logic          hp_reg, hp_next;
    logic          vv_reg, vv_next;
    logic [2:0]    verd_reg, verd_next;

    tcc_pkg::graph_wr_t gwr;
    logic [NW-1:0] node_raddr;
    logic [EW-1:0] edge_raddr;
    logic [10:0]   first_rd, last_rd;
    logic [9:0]    from_rd, to_rd;

    logic          vis_mem [MAX_NODES];
    logic          tch_mem [MAX_EDGES];
    logic [EW-1:0] stk_mem [MAX_NODES];
    logic          vis_we, vis_wd, tch_we, tch_wd, stk_we;
    logic [NW-1:0] vis_waddr, vis_raddr, stk_addr;
    logic [EW-1:0] tch_waddr, tch_raddr;
    logic          vis_rd, tch_rd;
    logic [EW-1:0] stk_rd;
    logic          accept;

    assign cfg_ready     = 1'b1;
    assign busy          = (state_reg != tcc_pkg::S_IDLE);
    assign verdict_valid = vv_reg;
    assign verdict       = verd_reg;
    assign accept        = start && !busy;

    assign n_eff = (node_count_reg == 11'd0) ? DW'(1) :
                   ((32'(node_count_reg) > MAX_NODES) ? DW'(MAX_NODES) : DW'(node_count_reg));
    assign edge_lim = {(n_eff - DW'(1)), 1'b0};

    assign gwr.node_we = accept && (func == tcc_pkg::FUNC_NODE) &&
                         (32'(entry_index) < MAX_NODES);
    assign gwr.edge_we = accept && (func == tcc_pkg::FUNC_EDGE) &&
                         (32'(entry_index) < MAX_EDGES);
    assign gwr.first   = range_first;
    assign gwr.last    = range_last;
    assign gwr.from    = edge_from;
    assign gwr.to      = edge_to;

    tcc_graph_store #(
        .MAX_NODES(MAX_NODES),
        .MAX_EDGES(MAX_EDGES)
    ) u_store (
        .clk       (clk),
        .wr        (gwr),
        .node_waddr(NW'(entry_index)),
        .edge_waddr(EW'(entry_index)),
        .node_raddr(node_raddr),
        .edge_raddr(edge_raddr),
        .first_rd  (first_rd),
        .last_rd   (last_rd),
        .from_rd   (from_rd),
        .to_rd     (to_rd)
    );

    always_ff @(posedge clk)
    begin
        if (vis_we)
        begin
            vis_mem[vis_waddr] <= vis_wd;
        end
        vis_rd <= vis_mem[vis_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tch_we)
        begin
            tch_mem[tch_waddr] <= tch_wd;
        end
        tch_rd <= tch_mem[tch_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_addr] <= e_reg;
        end
        stk_rd <= stk_mem[stk_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tcc_pkg::S_IDLE;
            node_count_reg <= 11'd1;
            vv_reg         <= 1'b0;
            depth_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            vv_reg    <= vv_next;
            depth_reg <= depth_next;
            if (cfg_valid && cfg_ready)
            begin
                node_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        clr_reg  <= clr_next;
        scan_reg <= scan_next;
        i_reg    <= i_next;
        last_reg <= last_next;
        e_reg    <= e_next;
        tgt_reg  <= tgt_next;
        curr_reg <= curr_next;
        par_reg  <= par_next;
        hp_reg   <= hp_next;
        verd_reg <= verd_next;
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        scan_next  = scan_reg;
        depth_next = depth_reg;
        i_next     = i_reg;
        last_next  = last_reg;
        e_next     = e_reg;
        tgt_next   = tgt_reg;
        curr_next  = curr_reg;
        par_next   = par_reg;
        hp_next    = hp_reg;
        verd_next  = verd_reg;
        vv_next    = 1'b0;
        node_raddr = curr_reg;
        edge_raddr = e_reg;
        vis_we     = 1'b0;
        vis_wd     = 1'b0;
        vis_waddr  = curr_reg;
        vis_raddr  = tgt_reg;
        tch_we     = 1'b0;
        tch_wd     = 1'b0;
        tch_waddr  = e_reg;
        tch_raddr  = EW'(32'(scan_reg) % MAX_EDGES);
        stk_we     = 1'b0;
        stk_addr   = depth_reg[NW-1:0];
        case (state_reg)
            tcc_pkg::S_IDLE:
            begin
                if (accept && (func == tcc_pkg::FUNC_CHECK))
                begin
                    clr_next   = '0;
                    depth_next = '0;
                    state_next = tcc_pkg::S_CLEAR;
                end
            end
            tcc_pkg::S_CLEAR:
            begin
                vis_we    = (32'(clr_reg) < MAX_NODES);
                vis_waddr = NW'(clr_reg);
                tch_we    = (32'(clr_reg) < MAX_EDGES);
                tch_waddr = EW'(clr_reg);
                clr_next  = clr_reg + CW'(1);
                if (32'(clr_reg) == MAXD - 1)
                begin
                    curr_next  = '0;
                    hp_next    = 1'b0;
                    depth_next = '0;
                    state_next = tcc_pkg::S_VISIT;
                end
            end
            tcc_pkg::S_VISIT:
            begin
                vis_we     = 1'b1;
                vis_wd     = 1'b1;
                state_next = tcc_pkg::S_RANGE;
            end
            tcc_pkg::S_RANGE:
            begin
                i_next    = first_rd;
                last_next = last_rd;
                e_next    = EW'(32'(first_rd) % MAX_EDGES);
                if (first_rd > last_rd)
                begin
                    state_next = tcc_pkg::S_NEXT;
                end
                else
                begin
                    state_next = tcc_pkg::S_EREAD;
                end
            end
            tcc_pkg::S_EREAD:
            begin
                tch_we     = 1'b1;
                tch_wd     = 1'b1;
                state_next = tcc_pkg::S_TREAD;
            end
            tcc_pkg::S_TREAD:
            begin
                tgt_next   = NW'(32'(to_rd) % MAX_NODES);
                vis_raddr  = NW'(32'(to_rd) % MAX_NODES);
                state_next = tcc_pkg::S_DECIDE;
            end
            tcc_pkg::S_DECIDE:
            begin
                if (!vis_rd && (depth_reg >= n_eff))
                begin
                    verd_next  = tcc_pkg::VERD_OVERFLOW;
                    vv_next    = 1'b1;
                    state_next = tcc_pkg::S_IDLE;
                end
                else if (vis_rd && hp_reg && (par_reg != tgt_reg))
                begin
                    verd_next  = tcc_pkg::VERD_CYCLE;
                    vv_next    = 1'b1;
                    state_next = tcc_pkg::S_IDLE;
                end
                else
                begin
                    if (!vis_rd)
                    begin
                        stk_we     = 1'b1;
                        depth_next = depth_reg + DW'(1);
                    end
                    if (i_reg == last_reg)
                    begin
                        state_next = tcc_pkg::S_NEXT;
                    end
                    else
                    begin
                        i_next     = i_reg + 11'd1;
                        e_next     = EW'(32'(i_reg + 11'd1) % MAX_EDGES);
                        state_next = tcc_pkg::S_EREAD;
                    end
                end
            end
            tcc_pkg::S_NEXT:
            begin
                if (depth_reg == '0)
                begin
                    scan_next  = '0;
                    state_next = tcc_pkg::S_SN_RD;
                end
                else
                begin
                    depth_next = depth_reg - DW'(1);
                    stk_addr   = NW'(depth_reg - DW'(1));
                    state_next = tcc_pkg::S_POP1;
                end
            end
            tcc_pkg::S_POP1:
            begin
                edge_raddr = stk_rd;
                state_next = tcc_pkg::S_POP2;
            end
            tcc_pkg::S_POP2:
            begin
                par_next   = NW'(32'(from_rd) % MAX_NODES);
                curr_next  = NW'(32'(to_rd) % MAX_NODES);
                hp_next    = 1'b1;
                state_next = tcc_pkg::S_VISIT;
            end
            tcc_pkg::S_SN_RD:
            begin
                vis_raddr  = NW'(scan_reg);
                state_next = tcc_pkg::S_SN_CK;
            end
            tcc_pkg::S_SN_CK:
            begin
                if (!vis_rd)
                begin
                    verd_next  = tcc_pkg::VERD_NODE;
                    vv_next    = 1'b1;
                    state_next = tcc_pkg::S_IDLE;
                end
                else if (scan_reg + (DW+1)'(1) == {1'b0, n_eff})
                begin
                    scan_next = '0;
                    if (edge_lim == '0)
                    begin
                        verd_next  = tcc_pkg::VERD_VALID;
                        vv_next    = 1'b1;
                        state_next = tcc_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = tcc_pkg::S_SE_RD;
                    end
                end
                else
                begin
                    scan_next  = scan_reg + (DW+1)'(1);
                    state_next = tcc_pkg::S_SN_RD;
                end
            end
            tcc_pkg::S_SE_RD:
            begin
                state_next = tcc_pkg::S_SE_CK;
            end
            tcc_pkg::S_SE_CK:
            begin
                if (!tch_rd)
                begin
                    verd_next  = tcc_pkg::VERD_EDGE;
                    vv_next    = 1'b1;
                    state_next = tcc_pkg::S_IDLE;
                end
                else if (scan_reg + (DW+1)'(1) == edge_lim)
                begin
                    verd_next  = tcc_pkg::VERD_VALID;
                    vv_next    = 1'b1;
                    state_next = tcc_pkg::S_IDLE;
                end
                else
                begin
                    scan_next  = scan_reg + (DW+1)'(1);
                    state_next = tcc_pkg::S_SE_RD;
                end
            end
            default:
            begin
                state_next = tcc_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid |-> !busy)
        else $error("verdict strobe while busy");
    a_check_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == tcc_pkg::FUNC_CHECK) |=> busy)
        else $error("check word did not start a walk");
    a_depth_cap: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (depth_reg <= n_eff))
        else $error("stack depth above node count");
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid |-> (verdict <= tcc_pkg::VERD_OVERFLOW))
        else $error("verdict code out of range");
`endif

endmodule

// ===== sim/tree_connectivity_cycle_check_tb.sv =====
// ---------------------------------------------------------------------------
// Tree connectivity cycle check testbench
// Loads node and edge words for small graphs, random-shape trees with some
// of them damaged, then issues check words. A scoreboard keeps its own
// copy of the graph stores and the node count, walks the graph for every
// accepted check word and compares each verdict with the oldest expected
// one. Checks that would read a store entry never written are not issued.
// ---------------------------------------------------------------------------
module tree_connectivity_cycle_check_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  f;
        logic [10:0] idx;
        logic [10:0] first;
        logic [10:0] last;
        logic [9:0]  from;
        logic [9:0]  to;
    } word_t;

    localparam logic [1:0] FUNC_NONE = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [10:0] cfg_data;
    logic        start;
    logic        busy;
    logic [1:0]  func;
    logic [10:0] entry_index;
    logic [10:0] range_first;
    logic [10:0] range_last;
    logic [9:0]  edge_from;
    logic [9:0]  edge_to;
    logic        verdict_valid;
    logic [2:0]  verdict;

    int errors = 0;
    int idle_pct = 0;
    int items_sent = 0;

    task automatic report_mismatch(string msg);
        errors++;
        $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    class tree_scoreboard;
        bit [10:0] range_lo[1024];
        bit [10:0] range_hi[1024];
        bit [9:0]  edge_src[2048];
        bit [9:0]  edge_dst[2048];
        bit        node_written[1024];
        bit        edge_written[2048];
        int        node_count_reg = 1;
        logic [2:0] verdict_q[$];

        function automatic logic [2:0] walk_tree(output bit clean);
            int n;
            bit seen[1024];
            bit touched[2048];
            int stk[1024];
            int depth;
            bit started;
            bit have_par;
            int par;
            int curr;
            int e;
            int tgt;
            clean = 1;
            n = (node_count_reg == 0) ? 1 : (node_count_reg > 1024 ? 1024 : node_count_reg);
            depth = 0;
            started = 0;
            have_par = 0;
            par = 0;
            curr = 0;
            while (!started || depth != 0)
            begin
                if (!started)
                begin
                    started = 1;
                    curr = 0;
                    have_par = 0;
                end
                else
                begin
                    depth--;
                    e = stk[depth];
                    if (!edge_written[e])
                        clean = 0;
                    par = edge_src[e];
                    curr = edge_dst[e];
                    have_par = 1;
                end
                seen[curr] = 1;
                if (!node_written[curr])
                    clean = 0;
                for (int i = range_lo[curr]; i <= int'(range_hi[curr]); i++)
                begin
                    e = i;
                    if (!edge_written[e])
                        clean = 0;
                    tgt = edge_dst[e];
                    touched[e] = 1;
                    if (!seen[tgt])
                    begin
                        if (depth >= n)
                            return tcc_pkg::VERD_OVERFLOW;
                        stk[depth] = e;
                        depth++;
                    end
                    else if (have_par && par != tgt)
                        return tcc_pkg::VERD_CYCLE;
                end
            end
            for (int i = 0; i < n; i++)
                if (!seen[i])
                    return tcc_pkg::VERD_NODE;
            for (int i = 0; i < 2 * (n - 1); i++)
                if (!touched[i])
                    return tcc_pkg::VERD_EDGE;
            return tcc_pkg::VERD_VALID;
        endfunction

        function automatic void note_word(word_t w);
            bit clean;
            case (w.f)
                tcc_pkg::FUNC_NODE:
                    if (w.idx < 1024)
                    begin
                        range_lo[w.idx] = w.first;
                        range_hi[w.idx] = w.last;
                        node_written[w.idx] = 1;
                    end
                tcc_pkg::FUNC_EDGE:
                begin
                    edge_src[w.idx] = w.from;
                    edge_dst[w.idx] = w.to;
                    edge_written[w.idx] = 1;
                end
                tcc_pkg::FUNC_CHECK:
                    verdict_q.push_back(walk_tree(clean));
                default:
                    ;
            endcase
        endfunction

        task check_verdict(logic [2:0] v);
            logic [2:0] want;
            if (verdict_q.size() == 0)
                report_mismatch($sformatf("verdict %0d with none expected", v));
            else
            begin
                want = verdict_q.pop_front();
                if (v !== want)
                    report_mismatch($sformatf("verdict %0d, expected %0d", v, want));
            end
        endtask
    endclass

    tree_scoreboard sb = new();

    tree_connectivity_cycle_check u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .entry_index  (entry_index),
        .range_first  (range_first),
        .range_last   (range_last),
        .edge_from    (edge_from),
        .edge_to      (edge_to),
        .verdict_valid(verdict_valid),
        .verdict      (verdict)
    );

    initial
    begin
        clk = 0;
    end

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(negedge clk)
    begin
        if (rst_n && verdict_valid)
            sb.check_verdict(verdict);
    end

    task automatic send_word(word_t w);
        bit taken;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 0;
            @(posedge clk);
        end
        start <= 1;
        func <= w.f;
        entry_index <= w.idx;
        range_first <= w.first;
        range_last <= w.last;
        edge_from <= w.from;
        edge_to <= w.to;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
        sb.note_word(w);
    endtask

    task automatic send(logic [1:0] f, int idx, int first, int last, int from, int to);
        word_t w;
        w = '{f, idx[10:0], first[10:0], last[10:0], from[9:0], to[9:0]};
        send_word(w);
        items_sent++;
    endtask

    task automatic send_check();
        bit clean;
        void'(sb.walk_tree(clean));
        if (clean)
            send(tcc_pkg::FUNC_CHECK, $urandom_range(2047), $urandom_range(2047),
                 $urandom_range(2047), $urandom_range(1023), $urandom_range(1023));
    endtask

    task automatic wait_idle();
        start <= 0;
        @(posedge clk);
        while (sb.verdict_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_node_count(int v);
        bit taken;
        wait_idle();
        cfg_valid <= 1;
        cfg_data <= v[10:0];
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_valid <= 0;
        sb.node_count_reg = v[10:0];
    endtask

    task automatic run_graph_set();
        int n;
        int cfgn;
        int par[64];
        int lo[64];
        int hi[64];
        int es[128];
        int et[128];
        int ne;
        int k;
        word_t words[$];
        word_t tmp;
        int j;
        n = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        par[0] = -1;
        for (int i = 1; i < n; i++)
            par[i] = $urandom_range(i - 1);
        ne = 0;
        for (int u = 0; u < n; u++)
        begin
            lo[u] = ne;
            for (int v = 0; v < n; v++)
                if (v != u && (par[v] == u || par[u] == v))
                begin
                    es[ne] = u;
                    et[ne] = v;
                    ne++;
                end
            hi[u] = ne - 1;
            if (ne == lo[u])
            begin
                lo[u] = ne + 1;
                hi[u] = ne;
            end
        end
        k = $urandom_range(n - 1);
        case ($urandom_range(9))
            0: if (ne > 0) et[$urandom_range(ne - 1)] = $urandom_range(n);
            1: if (lo[k] <= hi[k]) hi[k]--;
            2: if (ne > 0 && lo[k] <= hi[k] && hi[k] < ne - 1) hi[k]++;
            3: begin lo[k] = 1; hi[k] = 0; end
            4: if (ne > 0) es[$urandom_range(ne - 1)] = $urandom_range(n - 1);
            default: ;
        endcase
        cfgn = n;
        if ($urandom_range(6) == 0)
            cfgn = n + 1 - $urandom_range(2);
        if (cfgn != sb.node_count_reg)
            write_node_count(cfgn);
        for (int u = 0; u < n; u++)
            words.push_back('{tcc_pkg::FUNC_NODE, u[10:0], lo[u][10:0], hi[u][10:0],
                              10'($urandom), 10'($urandom)});
        for (int i = 0; i < ne; i++)
            words.push_back('{tcc_pkg::FUNC_EDGE, i[10:0], 11'($urandom), 11'($urandom),
                              es[i][9:0], et[i][9:0]});
        items_sent += words.size();
        for (int i = $urandom_range(3); i > 0; i--)
            case ($urandom_range(3))
                0: words.push_back('{FUNC_NONE, 11'($urandom), 11'($urandom),
                                     11'($urandom), 10'($urandom), 10'($urandom)});
                1: words.push_back('{tcc_pkg::FUNC_NODE, 11'($urandom_range(2047, 1024)),
                                     11'($urandom), 11'($urandom),
                                     10'($urandom), 10'($urandom)});
                2: words.push_back('{tcc_pkg::FUNC_NODE, 11'($urandom_range(1023, 512)),
                                     11'($urandom), 11'($urandom),
                                     10'($urandom), 10'($urandom)});
                default: words.push_back('{tcc_pkg::FUNC_EDGE,
                                           11'($urandom_range(2047, 1024)),
                                           11'($urandom), 11'($urandom),
                                           10'($urandom), 10'($urandom)});
            endcase
        for (int i = words.size() - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            tmp = words[i];
            words[i] = words[j];
            words[j] = tmp;
        end
        foreach (words[i])
            send_word(words[i]);
        send_check();
        if ($urandom_range(3) == 0)
            send_check();
    endtask

    initial
    begin
        int sets;
        int wait_cycles;
        rst_n = 0;
        cfg_valid = 0;
        cfg_data = 0;
        start = 0;
        func = 0;
        entry_index = 0;
        range_first = 0;
        range_last = 0;
        edge_from = 0;
        edge_to = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send(tcc_pkg::FUNC_NODE, 0, 1, 0, 0, 0);
        send_check();
        send(FUNC_NONE, 2047, 2047, 2047, 1023, 1023);
        send(tcc_pkg::FUNC_NODE, 2047, 2047, 2047, 1023, 1023);
        send(tcc_pkg::FUNC_EDGE, 2047, 2047, 2047, 1023, 1023);
        send(tcc_pkg::FUNC_NODE, 1023, 1, 0, 0, 0);
        send(tcc_pkg::FUNC_NODE, 0, 2047, 2047, 0, 0);
        send_check();
        send(tcc_pkg::FUNC_EDGE, 2046, 0, 0, 0, 5);
        send(tcc_pkg::FUNC_NODE, 0, 2046, 2047, 0, 0);
        send_check();
        write_node_count(2);
        send(tcc_pkg::FUNC_NODE, 0, 0, 0, 0, 0);
        send(tcc_pkg::FUNC_NODE, 1, 1, 1, 0, 0);
        send(tcc_pkg::FUNC_EDGE, 0, 0, 0, 0, 1);
        send(tcc_pkg::FUNC_EDGE, 1, 0, 0, 1, 0);
        send_check();
        send(tcc_pkg::FUNC_EDGE, 1, 0, 0, 1, 1);
        send_check();
        write_node_count(0);
        send_check();
        write_node_count(2047);
        send_check();
        write_node_count(1024);
        send_check();
        write_node_count(3);
        send_check();

        sets = 0;
        while (items_sent < 1750)
        begin
            case ((sets / 8) % 4)
                0: idle_pct = 0;
                1: idle_pct = 47;
                2: idle_pct = 0;
                default: idle_pct = 25;
            endcase
            if (sets % 10 == 5)
                wait_idle();
            run_graph_set();
            sets++;
        end

        start <= 0;
        @(posedge clk);
        wait_cycles = 0;
        while (sb.verdict_q.size() != 0 && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (50) @(posedge clk);
        if (errors == 0 && sb.verdict_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tcc_pkg.sv
rtl/tcc_graph_store.sv
rtl/tree_connectivity_cycle_check.sv
sim/tree_connectivity_cycle_check_tb.sv
